// File: hw/rtl/ucsr_pkg.sv
`timescale 1ns / 1ps

package ucsr_pkg;

    // Line store geometry
    localparam int LINE_BYTES = 15;
    localparam int IDX_W      = $clog2(LINE_BYTES);
    localparam int FILL_W     = $clog2(LINE_BYTES + 1);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int PULSE_W = 11;

    // Newline character that ends a line
    localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;

    // Reset values of the pulse width registers
    localparam logic [PULSE_W-1:0] PULSE_ZERO_RST   = 11'd50;
    localparam logic [PULSE_W-1:0] PULSE_NINETY_RST = 11'd150;
    localparam logic [PULSE_W-1:0] PULSE_FULL_RST   = 11'd250;

    // Configuration register indexes
    localparam logic [1:0] REG_ZERO   = 2'd0;
    localparam logic [1:0] REG_NINETY = 2'd1;
    localparam logic [1:0] REG_FULL   = 2'd2;

    // Command text table, in match priority order
    localparam int NUM_CMDS    = 7;
    localparam int CMD_MAX     = 11;
    localparam int CMD_LED_ON  = 0;
    localparam int CMD_LED_OFF = 1;
    localparam int CMD_SRV_0   = 2;
    localparam int CMD_SRV_90  = 3;
    localparam int CMD_SRV_180 = 4;
    localparam int CMD_REP_OFF = 5;
    localparam int CMD_REP_ON  = 6;

    typedef logic [8*CMD_MAX-1:0] cmd_text_t;

    // Each string is right-justified: its last character sits in the low byte.
    localparam cmd_text_t CMD_TEXT [NUM_CMDS] = '{
        "LED1=1\n",
        "LED1=0\n",
        "SERVO=0\n",
        "SERVO=90\n",
        "SERVO=180\n",
        "REPEAT=OFF\n",
        "REPEAT=ON\n"
    };
    localparam int CMD_LEN [NUM_CMDS] = '{7, 7, 8, 9, 10, 11, 10};

    // Pending command codes
    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_LED_ON,
        PEND_LED_OFF,
        PEND_SERVO_0,
        PEND_SERVO_90,
        PEND_SERVO_180
    } pend_t;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_STORE,
        OP_MATCH,
        OP_ECHO,
        OP_CLEAR,
        OP_RESULT,
        OP_TICK
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IS_TICK,
        COND_NOT_NL,
        COND_ECHO_OFF,
        COND_MORE
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_STORE    = 4'd1;
    localparam step_t STEP_MATCH    = 4'd2;
    localparam step_t STEP_BRANCH   = 4'd3;
    localparam step_t STEP_ECHO     = 4'd4;
    localparam step_t STEP_ECHO_CLR = 4'd5;
    localparam step_t STEP_LINE_CLR = 4'd6;
    localparam step_t STEP_RESULT   = 4'd7;
    localparam step_t STEP_TICK     = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status the datapath returns to the sequencer
    typedef struct packed {
        logic go;
        logic is_tick;
        logic not_nl;
        logic echo_off;
        logic more;
    } seq_status_t;

    // Control program: the jump is taken when the condition holds,
    // otherwise the step counter advances by one.
    function automatic ctrl_word_t ucsr_rom(input step_t step);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT:     w = '{op: OP_WAIT,   cond: COND_IS_TICK,  target: STEP_TICK};
            STEP_STORE:    w = '{op: OP_STORE,  cond: COND_NOT_NL,   target: STEP_RESULT};
            STEP_MATCH:    w = '{op: OP_MATCH,  cond: COND_NEVER,    target: STEP_WAIT};
            STEP_BRANCH:   w = '{op: OP_NOP,    cond: COND_ECHO_OFF, target: STEP_LINE_CLR};
            STEP_ECHO:     w = '{op: OP_ECHO,   cond: COND_MORE,     target: STEP_ECHO};
            STEP_ECHO_CLR: w = '{op: OP_CLEAR,  cond: COND_ALWAYS,   target: STEP_WAIT};
            STEP_LINE_CLR: w = '{op: OP_CLEAR,  cond: COND_NEVER,    target: STEP_WAIT};
            STEP_RESULT:   w = '{op: OP_RESULT, cond: COND_ALWAYS,   target: STEP_WAIT};
            STEP_TICK:     w = '{op: OP_TICK,   cond: COND_ALWAYS,   target: STEP_RESULT};
            default:       w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/ucsr_sequencer.sv
`timescale 1ns / 1ps

module ucsr_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  ucsr_pkg::seq_status_t status,
    output ucsr_pkg::op_t       op
);
    import ucsr_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       jump;

    // Control word of the current step
    assign word = ucsr_rom(step_reg);
    assign op   = word.op;

    // Jump condition decode
    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_IS_TICK:  jump = status.is_tick;
            COND_NOT_NL:   jump = status.not_nl;
            COND_ECHO_OFF: jump = status.echo_off;
            COND_MORE:     jump = status.more;
            default:       jump = 1'b1;
        endcase
    end

    // The step holds while the datapath waits on a handshake.
    always_comb
    begin
        step_next = step_reg;
        if (status.go)
        begin
            step_next = jump ? word.target : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: hw/rtl/uart_command_servo_ramp_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: rx_byte; tuser: command
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: levels and echo byte;
//                                                     tuser: tx_valid; tlast: last
// apb       in         psel, penable, pready          pulse width registers at 0, 4, 8
//
// A tick runs the wait, tick and result steps; a plain byte the wait, store and
// result steps. A newline is matched; without echo the line is cleared before the
// result step, with echo one line byte leaves per cycle while the output is free.
// Reset is asynchronous and resets every state register, the line store included;
// the payload registers are loaded before they are read.
// A stalled output holds the program in its result or echo step; a new input is
// taken while the last result still waits in the output register.

module uart_command_servo_ramp_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] tx_byte, [8] led_on, [19:9] pulse_width,
                                        // [20] moving, [21] repeat_on, [23:22] zero
    output logic [0:0]  m_axis_tuser,   // [0] tx_valid
    output logic        m_axis_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ucsr_pkg::*;

    // Configuration registers
    logic [PULSE_W-1:0] zero_reg, zero_next;
    logic [PULSE_W-1:0] ninety_reg, ninety_next;
    logic [PULSE_W-1:0] full_reg, full_next;

    // Line state
    logic [BYTE_W-1:0]  store_reg [LINE_BYTES];
    logic [BYTE_W-1:0]  store_next [LINE_BYTES];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               overflow_reg, overflow_next;
    logic [BYTE_W-1:0]  rx_byte_reg, rx_byte_next;
    logic [IDX_W-1:0]   echo_idx_reg, echo_idx_next;

    // Control levels
    pend_t              pend_reg, pend_next;
    logic               echo_mode_reg, echo_mode_next;
    logic               led_reg, led_next;
    logic [PULSE_W-1:0] pos_reg, pos_next;
    logic [PULSE_W-1:0] target_reg, target_next;
    logic               active_reg, active_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_txv_reg, out_txv_next;
    logic               out_last_reg, out_last_next;
    logic               out_led_reg, out_led_next;
    logic [PULSE_W-1:0] out_pos_reg, out_pos_next;
    logic               out_moving_reg, out_moving_next;
    logic               out_repeat_reg, out_repeat_next;

    op_t                op;
    seq_status_t        status;
    logic               in_accept;
    logic               slot_free;
    logic               cfg_write;
    logic [1:0]         cfg_idx;
    logic [NUM_CMDS-1:0] hit;

    // Sequencer
    ucsr_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    // Handshakes
    assign s_axis_tready = (op == OP_WAIT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        unique case (op)
            OP_WAIT:   status.go = in_accept;
            OP_ECHO:   status.go = slot_free;
            OP_RESULT: status.go = slot_free;
            default:   status.go = 1'b1;
        endcase
        status.is_tick  = s_axis_tuser[0];
        status.not_nl   = (rx_byte_reg != CHAR_NL);
        status.echo_off = !echo_mode_reg;
        status.more     = (echo_idx_reg != IDX_W'(LINE_BYTES - 1));
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_ZERO:   prdata = {{(32 - PULSE_W){1'b0}}, zero_reg};
            REG_NINETY: prdata = {{(32 - PULSE_W){1'b0}}, ninety_reg};
            REG_FULL:   prdata = {{(32 - PULSE_W){1'b0}}, full_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        zero_next   = zero_reg;
        ninety_next = ninety_reg;
        full_next   = full_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ZERO:   zero_next   = pwdata[PULSE_W-1:0];
                REG_NINETY: ninety_next = pwdata[PULSE_W-1:0];
                REG_FULL:   full_next   = pwdata[PULSE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Exact line match against each command text
    always_comb
    begin
        int p;
        for (int k = 0; k < NUM_CMDS; k++)
        begin
            hit[k] = !overflow_reg && (fill_reg == FILL_W'(CMD_LEN[k]));
            for (int i = 0; i < CMD_MAX; i++)
            begin
                p = CMD_LEN[k] - 1 - i;
                if (p >= 0)
                begin
                    if (store_reg[i] != CMD_TEXT[k][8*p +: 8])
                    begin
                        hit[k] = 1'b0;
                    end
                end
            end
        end
    end

    // Datapath operations
    always_comb
    begin
        logic [PULSE_W-1:0] step_pos;
        logic [PULSE_W-1:0] new_target;
        logic               start;

        store_next      = store_reg;
        fill_next       = fill_reg;
        overflow_next   = overflow_reg;
        rx_byte_next    = rx_byte_reg;
        echo_idx_next   = echo_idx_reg;
        pend_next       = pend_reg;
        echo_mode_next  = echo_mode_reg;
        led_next        = led_reg;
        pos_next        = pos_reg;
        target_next     = target_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_txv_next    = out_txv_reg;
        out_last_next   = out_last_reg;
        out_led_next    = out_led_reg;
        out_pos_next    = out_pos_reg;
        out_moving_next = out_moving_reg;
        out_repeat_next = out_repeat_reg;
        step_pos        = pos_reg;
        new_target      = pos_reg;
        start           = 1'b0;

        unique case (op)
            OP_NOP:
            begin
            end
            OP_WAIT:
            begin
                if (in_accept)
                begin
                    rx_byte_next = s_axis_tdata[BYTE_W-1:0];
                end
            end
            OP_STORE:
            begin
                // A byte that finds the store full is dropped.
                if (fill_reg < FILL_W'(LINE_BYTES))
                begin
                    store_next[fill_reg[IDX_W-1:0]] = rx_byte_reg;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
            OP_MATCH:
            begin
                priority if (hit[CMD_LED_ON])  pend_next = PEND_LED_ON;
                else if (hit[CMD_LED_OFF])     pend_next = PEND_LED_OFF;
                else if (hit[CMD_SRV_0])       pend_next = PEND_SERVO_0;
                else if (hit[CMD_SRV_90])      pend_next = PEND_SERVO_90;
                else if (hit[CMD_SRV_180])     pend_next = PEND_SERVO_180;
                else if (hit[CMD_REP_OFF])     echo_mode_next = 1'b0;
                else if (hit[CMD_REP_ON])      echo_mode_next = 1'b1;
                else                           pend_next = pend_reg;
            end
            OP_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = store_reg[echo_idx_reg];
                    out_txv_next    = 1'b1;
                    out_last_next   = !status.more;
                    out_led_next    = led_reg;
                    out_pos_next    = pos_reg;
                    out_moving_next = active_reg;
                    out_repeat_next = echo_mode_reg;
                    echo_idx_next   = echo_idx_reg + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < LINE_BYTES; i++)
                begin
                    store_next[i] = '0;
                end
                fill_next     = '0;
                overflow_next = 1'b0;
                echo_idx_next = '0;
            end
            OP_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_txv_next    = 1'b0;
                    out_last_next   = 1'b1;
                    out_led_next    = led_reg;
                    out_pos_next    = pos_reg;
                    out_moving_next = active_reg;
                    out_repeat_next = echo_mode_reg;
                end
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    // One count per tick toward the target
                    if (pos_reg < target_reg)
                    begin
                        step_pos = pos_reg + 1'b1;
                    end
                    else if (pos_reg > target_reg)
                    begin
                        step_pos = pos_reg - 1'b1;
                    end
                    pos_next = step_pos;
                    if (step_pos == target_reg)
                    begin
                        active_next = 1'b0;
                    end
                end
                else if (pend_reg != PEND_NONE)
                begin
                    unique case (pend_reg)
                        PEND_LED_ON:  led_next = 1'b1;
                        PEND_LED_OFF: led_next = 1'b0;
                        PEND_SERVO_0:
                        begin
                            if (pos_reg > zero_reg)
                            begin
                                start      = 1'b1;
                                new_target = zero_reg;
                            end
                        end
                        PEND_SERVO_90:
                        begin
                            // Only from the exact full or zero width
                            if (pos_reg == full_reg)
                            begin
                                if (pos_reg > ninety_reg)
                                begin
                                    start      = 1'b1;
                                    new_target = ninety_reg;
                                end
                            end
                            else if (pos_reg == zero_reg)
                            begin
                                if (pos_reg < ninety_reg)
                                begin
                                    start      = 1'b1;
                                    new_target = ninety_reg;
                                end
                            end
                        end
                        PEND_SERVO_180:
                        begin
                            if (pos_reg < full_reg)
                            begin
                                start      = 1'b1;
                                new_target = full_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (start)
                    begin
                        target_next = new_target;
                        active_next = (pos_reg != new_target);
                    end
                    pend_next = PEND_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg       <= PULSE_ZERO_RST;
            ninety_reg     <= PULSE_NINETY_RST;
            full_reg       <= PULSE_FULL_RST;
            for (int i = 0; i < LINE_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
            echo_idx_reg   <= '0;
            pend_reg       <= PEND_NONE;
            echo_mode_reg  <= 1'b0;
            led_reg        <= 1'b0;
            pos_reg        <= PULSE_NINETY_RST;
            target_reg     <= PULSE_NINETY_RST;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            zero_reg       <= zero_next;
            ninety_reg     <= ninety_next;
            full_reg       <= full_next;
            store_reg      <= store_next;
            fill_reg       <= fill_next;
            overflow_reg   <= overflow_next;
            echo_idx_reg   <= echo_idx_next;
            pend_reg       <= pend_next;
            echo_mode_reg  <= echo_mode_next;
            led_reg        <= led_next;
            pos_reg        <= pos_next;
            target_reg     <= target_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rx_byte_reg    <= rx_byte_next;
        out_byte_reg   <= out_byte_next;
        out_txv_reg    <= out_txv_next;
        out_last_reg   <= out_last_next;
        out_led_reg    <= out_led_next;
        out_pos_reg    <= out_pos_next;
        out_moving_reg <= out_moving_next;
        out_repeat_reg <= out_repeat_next;
    end

    // Result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_repeat_reg, out_moving_reg, out_pos_reg,
                            out_led_reg, out_byte_reg};
    assign m_axis_tuser  = out_txv_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    // The fill count never runs past the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_BYTES))
    else $error("line fill count beyond store size");

    // A move in progress has not yet reached its target.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg != target_reg))
    else $error("ramp active at its target");

    // The final echo byte leaves marked as the last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ECHO && slot_free && !status.more) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final echo byte not marked last");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ucsr_pkg::*;

    // Run limits and the pause that lets a finished line echo drain.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned PULSE_MAX    = 2000;
    localparam int unsigned LOW_WIDTH    = 24;
    localparam int unsigned NUM_LINES    = 7;
    localparam int unsigned NUM_STAGES   = 6;
    localparam int unsigned STAGE_ITEMS  = 30;

    // Register index just past the three pulse widths; writes to it are ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef logic [BYTE_W-1:0] octet_t;

    // Command lines the block recognizes.
    typedef enum int
    {
        LN_LED_ON,
        LN_LED_OFF,
        LN_SERVO_0,
        LN_SERVO_90,
        LN_SERVO_180,
        LN_REPEAT_ON,
        LN_REPEAT_OFF
    } line_kind_t;

    // One result transaction as the block should present it.
    typedef struct {
        octet_t             tx_byte;
        bit                 tx_valid;
        bit                 last;
        bit                 led_on;
        logic [PULSE_W-1:0] pulse_width;
        bit                 moving;
        bit                 echo_on;
    } beat_t;

    // Tracks the line store, pending command and servo ramp, and holds the
    // result transactions that are still owed by the block.
    class servo_line_tracker_t;
        octet_t             line_buf[LINE_BYTES];
        int unsigned        fill;
        bit                 overflow;
        pend_t              pending;
        bit                 echo_on;
        bit                 led_on;
        bit                 ramping;
        logic [PULSE_W-1:0] position;
        logic [PULSE_W-1:0] target;
        logic [PULSE_W-1:0] width_zero;
        logic [PULSE_W-1:0] width_ninety;
        logic [PULSE_W-1:0] width_full;
        octet_t             cmd_text[NUM_LINES][$];
        beat_t              due_beats[$];
        int unsigned        errors;

        function new();
            string words[NUM_LINES];
            words[LN_LED_ON]     = "LED1=1\n";
            words[LN_LED_OFF]    = "LED1=0\n";
            words[LN_SERVO_0]    = "SERVO=0\n";
            words[LN_SERVO_90]   = "SERVO=90\n";
            words[LN_SERVO_180]  = "SERVO=180\n";
            words[LN_REPEAT_ON]  = "REPEAT=ON\n";
            words[LN_REPEAT_OFF] = "REPEAT=OFF\n";
            foreach (words[k])
            begin
                for (int i = 0; i < words[k].len(); i++)
                    cmd_text[k].push_back(words[k][i]);
            end
            foreach (line_buf[i])
                line_buf[i] = '0;
            fill         = 0;
            overflow     = 1'b0;
            pending      = PEND_NONE;
            echo_on      = 1'b0;
            led_on       = 1'b0;
            ramping      = 1'b0;
            position     = PULSE_NINETY_RST;
            target       = PULSE_NINETY_RST;
            width_zero   = PULSE_ZERO_RST;
            width_ninety = PULSE_NINETY_RST;
            width_full   = PULSE_FULL_RST;
            errors       = 0;
        endfunction

        function int unsigned waiting();
            return due_beats.size();
        endfunction

        function void set_width(logic [1:0] idx, logic [PULSE_W-1:0] value);
            case (idx)
                REG_ZERO:   width_zero   = value;
                REG_NINETY: width_ninety = value;
                REG_FULL:   width_full   = value;
                default:    ;
            endcase
        endfunction

        // A line matches only with exactly the command's bytes and no overflow.
        function bit line_matches(int kind);
            if (overflow || fill != cmd_text[kind].size())
                return 1'b0;
            for (int i = 0; i < fill; i++)
            begin
                if (line_buf[i] != cmd_text[kind][i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void start_move(logic [PULSE_W-1:0] goal);
            target  = goal;
            ramping = (position != goal);
        endfunction

        function void push_beat(octet_t tx_byte, bit tx_valid, bit last);
            beat_t b;
            b.tx_byte     = tx_byte;
            b.tx_valid    = tx_valid;
            b.last        = last;
            b.led_on      = led_on;
            b.pulse_width = position;
            b.moving      = ramping;
            b.echo_on     = echo_on;
            due_beats.push_back(b);
        endfunction

        // Advance the tracked state by one accepted input transaction.
        function void take_input(bit tick, octet_t data);
            if (tick)
            begin
                // A move in progress steps once; otherwise a pending command is applied.
                if (ramping)
                begin
                    if (position < target)
                        position++;
                    else if (position > target)
                        position--;
                    if (position == target)
                        ramping = 1'b0;
                end
                else if (pending != PEND_NONE)
                begin
                    case (pending)
                        PEND_LED_ON:  led_on = 1'b1;
                        PEND_LED_OFF: led_on = 1'b0;
                        PEND_SERVO_0:
                            if (position > width_zero)
                                start_move(width_zero);
                        PEND_SERVO_90:
                            if (position == width_full)
                            begin
                                if (position > width_ninety)
                                    start_move(width_ninety);
                            end
                            else if (position == width_zero)
                            begin
                                if (position < width_ninety)
                                    start_move(width_ninety);
                            end
                        PEND_SERVO_180:
                            if (position < width_full)
                                start_move(width_full);
                        default: ;
                    endcase
                    pending = PEND_NONE;
                end
                push_beat('0, 1'b0, 1'b1);
                return;
            end

            // A byte that finds the store full is dropped and spoils the line.
            if (fill < LINE_BYTES)
            begin
                line_buf[fill] = data;
                fill++;
            end
            else
                overflow = 1'b1;

            if (data != CHAR_NL)
            begin
                push_beat('0, 1'b0, 1'b1);
                return;
            end

            // End of line: match, then echo the whole store or report once.
            if (line_matches(LN_LED_ON))
                pending = PEND_LED_ON;
            else if (line_matches(LN_LED_OFF))
                pending = PEND_LED_OFF;
            else if (line_matches(LN_SERVO_0))
                pending = PEND_SERVO_0;
            else if (line_matches(LN_SERVO_90))
                pending = PEND_SERVO_90;
            else if (line_matches(LN_SERVO_180))
                pending = PEND_SERVO_180;
            else if (line_matches(LN_REPEAT_OFF))
                echo_on = 1'b0;
            else if (line_matches(LN_REPEAT_ON))
                echo_on = 1'b1;

            if (echo_on)
            begin
                for (int k = 0; k < LINE_BYTES; k++)
                    push_beat(line_buf[k], 1'b1, k == LINE_BYTES - 1);
            end
            else
                push_beat('0, 1'b0, 1'b1);

            foreach (line_buf[i])
                line_buf[i] = '0;
            fill     = 0;
            overflow = 1'b0;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result transaction with the oldest one owed.
        function void check_beat(logic [23:0] data, logic tx_valid, logic last);
            beat_t want;
            if (due_beats.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
                         $time, data, tx_valid, last);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            compare_field("tx_byte", want.tx_byte, data[7:0]);
            compare_field("led_on", want.led_on, data[8]);
            compare_field("pulse_width", want.pulse_width, data[19:9]);
            compare_field("moving", want.moving, data[20]);
            compare_field("repeat_on", want.echo_on, data[21]);
            compare_field("tdata padding", 0, data[23:22]);
            compare_field("tx_valid", want.tx_valid, tx_valid);
            compare_field("last", want.last, last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] tx_byte, [8] led_on, [19:9] pulse_width,
                                 // [20] moving, [21] repeat_on, [23:22] zero
    logic [0:0]  m_axis_tuser;   // [0] tx_valid
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    servo_line_tracker_t tracker;
    bit                  calm;
    int unsigned         holds_asked;
    int unsigned         items_sent;
    int unsigned         cycle_count = 0;

    uart_command_servo_ramp_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("uart_command_servo_ramp_unit regression: fail");
            $finish;
        end
    end

    // Result side: check every accepted transaction, stall at random, and
    // hold off for a long stretch whenever the stimulus asks for it.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned holds_served;
        stall_left    = 0;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_beat(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic pause_input(int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one input transaction and wait until the block takes it. Valid
    // stays high afterwards so that a following item goes out back to back.
    task automatic send_item(bit tick, octet_t data);
        if (!calm && $urandom_range(99) < 7)
            pause_input($urandom_range(1, 6));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= tick;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_input(tick, data);
        items_sent++;
    endtask

    // The byte field is ignored on a tick, so it carries random content.
    task automatic send_ticks(int unsigned n);
        repeat (n) send_item(1'b1, octet_t'($urandom_range(255)));
    endtask

    task automatic send_bytes(octet_t q[$]);
        foreach (q[i])
            send_item(1'b0, q[i]);
    endtask

    task automatic send_line(int kind);
        send_bytes(tracker.cmd_text[kind]);
    endtask

    // Keep ticking until no move is running and no command waits.
    task automatic run_until_parked();
        while (tracker.ramping || tracker.pending != PEND_NONE)
            send_ticks(1);
    endtask

    // Let every owed result arrive, then give the block time to go idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup phase, then access phase. Bits above the
    // register width carry junk that the block must drop.
    task automatic write_width(logic [1:0] idx, logic [PULSE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_width(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Widths close to the present position keep servo moves short; now and
    // then zero and full trade places.
    task automatic set_near_widths();
        int lo;
        int hi;
        int mid;
        int tmp;
        lo  = int'(tracker.position) - int'($urandom_range(0, 10));
        hi  = int'(tracker.position) + int'($urandom_range(0, 10));
        if (lo < 0)
            lo = 0;
        if (hi > int'(PULSE_MAX))
            hi = PULSE_MAX;
        mid = $urandom_range(lo, hi);
        if ($urandom_range(3) == 0)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        write_width(REG_ZERO, PULSE_W'(lo));
        write_width(REG_NINETY, PULSE_W'(mid));
        write_width(REG_FULL, PULSE_W'(hi));
    endtask

    // Mostly well-formed commands followed by ticks, plus damaged commands,
    // long lines, loose bytes and runs of ticks.
    task automatic random_traffic(int unsigned count);
        int unsigned goal;
        int unsigned pick;
        octet_t      q[$];
        octet_t      b;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            q    = {};
            if (pick < 45)
            begin
                send_line($urandom_range(NUM_LINES - 1));
                send_ticks($urandom_range(1, 12));
            end
            else if (pick < 57)
                send_ticks($urandom_range(1, 8));
            else if (pick < 67)
            begin
                // A command with one byte changed, added or missing.
                q = tracker.cmd_text[$urandom_range(NUM_LINES - 1)];
                case ($urandom_range(2))
                    0:       q[$urandom_range(q.size() - 1)] = octet_t'($urandom_range(255));
                    1:       q.insert($urandom_range(q.size() - 1), octet_t'($urandom_range(255)));
                    default: q.delete($urandom_range(q.size() - 2));
                endcase
                send_bytes(q);
            end
            else if (pick < 77)
            begin
                // Lines that just fit, fill the store exactly, or overflow it.
                repeat ($urandom_range(13, 20))
                begin
                    b = octet_t'($urandom_range(255));
                    if (b == CHAR_NL)
                        b = 8'h20;
                    q.push_back(b);
                end
                q.push_back(CHAR_NL);
                send_bytes(q);
            end
            else if (pick < 87)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(1'b0, octet_t'($urandom_range(255)));
            end
            else
                send_ticks($urandom_range(10, 30));
        end
    endtask

    // Stimulus: directed items, then stages of random traffic under
    // different width settings, with the extreme settings in the middle.
    initial
    begin : stimulus
        int unsigned stage;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        holds_asked   = 0;
        items_sent    = 0;
        rst_n         = 1'b0;
        tracker       = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Close widths keep the first moves short; the spare index is ignored.
        write_width(REG_ZERO, PULSE_W'(148));
        write_width(REG_NINETY, PULSE_W'(150));
        write_width(REG_FULL, PULSE_W'(152));
        write_width(REG_SPARE, PULSE_W'(PULSE_MAX));

        // Extreme byte values ending in a line that matches nothing, a tick
        // with nothing pending, then a pending command replaced by a later one.
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CHAR_NL);
        send_ticks(1);
        send_line(LN_SERVO_0);
        send_line(LN_LED_ON);
        send_ticks(1);
        settle();

        for (stage = 0; stage < NUM_STAGES; stage++)
        begin
            if (stage == 3)
            begin
                // Zero width at the bottom: ramp down to zero, then up to a low
                // ninety width that the full width equals.
                write_width(REG_ZERO, '0);
                write_width(REG_NINETY, PULSE_W'(LOW_WIDTH));
                write_width(REG_FULL, PULSE_W'(LOW_WIDTH));
                run_until_parked();
                send_line(LN_SERVO_0);
                run_until_parked();
                send_line(LN_SERVO_90);
                run_until_parked();
                // At the full width but not above ninety: nothing moves.
                send_line(LN_SERVO_90);
                send_line(LN_SERVO_180);
                run_until_parked();
                settle();

                // Reversed extremes: no command can start a move.
                write_width(REG_ZERO, PULSE_W'(PULSE_MAX));
                write_width(REG_NINETY, '0);
                write_width(REG_FULL, '0);
                send_line(LN_SERVO_0);
                send_ticks(1);
                send_line(LN_SERVO_90);
                send_ticks(1);
                send_line(LN_SERVO_180);
                send_ticks(1);
                settle();
            end

            set_near_widths();
            calm = (stage == 1);
            if (stage == 4)
            begin
                // Echo fills the output fast while the result side holds off.
                send_line(LN_REPEAT_ON);
                holds_asked++;
            end
            random_traffic(STAGE_ITEMS);
            calm = 1'b0;
            settle();
        end

        if (tracker.errors == 0)
            $display("uart_command_servo_ramp_unit regression: pass");
        else
            $display("uart_command_servo_ramp_unit regression: fail");
        $finish;
    end

endmodule
